// ===== hdl/lr_pkg.sv =====
`timescale 1ns / 1ps

package lr_pkg;

  // Defaults for the top-level parameters
  localparam int LR_SCREEN_WIDTH  = 1920;
  localparam int LR_SCREEN_HEIGHT = 1080;
  localparam int LR_COORD_BITS    = 12;

  // Depth of the queue between setup and stepping (power of two, at least 2)
  localparam int LR_QUEUE_DEPTH = 2;

  // Packed colour: red in the top byte, blue in the bottom byte
  localparam int LR_CHAN_BITS   = 8;
  localparam int LR_COLOUR_BITS = 3 * LR_CHAN_BITS;

  // Request codes
  typedef enum logic [0:0] {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  // Step directions found by the setup stage
  typedef struct packed {
    logic x_neg;
    logic y_neg;
  } dir_flags_t;

  localparam int LR_DIR_BITS = $bits(dir_flags_t);

endpackage

// ===== hdl/lr_front.sv =====
`timescale 1ns / 1ps

module lr_front
  import lr_pkg::*;
#(
  parameter int COORD_BITS = LR_COORD_BITS
) (
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic [COORD_BITS-1:0] delta_x,
  output logic [COORD_BITS-1:0] delta_y,
  output dir_flags_t            dir
);

  // Absolute spans and step directions of the new line
  always_comb begin
    dir.x_neg = end_x < start_x;
    dir.y_neg = end_y < start_y;
    delta_x   = dir.x_neg ? (start_x - end_x) : (end_x - start_x);
    delta_y   = dir.y_neg ? (start_y - end_y) : (end_y - start_y);
  end

endmodule

// ===== hdl/lr_fifo.sv =====
`timescale 1ns / 1ps

module lr_fifo
  import lr_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = LR_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_pop,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push;
  logic             pop;

  assign wr_ready = count_r != CW'(DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_data  = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  // Pointers wrap naturally since the depth is a power of two
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== hdl/lr_back.sv =====
`timescale 1ns / 1ps

module lr_back
  import lr_pkg::*;
#(
  parameter int COORD_BITS = LR_COORD_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // queue side
  input  logic                      q_valid,
  output logic                      q_pop,
  input  cmd_t                      q_cmd,
  input  logic [COORD_BITS-1:0]     q_start_x,
  input  logic [COORD_BITS-1:0]     q_start_y,
  input  logic [COORD_BITS-1:0]     q_end_x,
  input  logic [COORD_BITS-1:0]     q_end_y,
  input  logic [COORD_BITS-1:0]     q_delta_x,
  input  logic [COORD_BITS-1:0]     q_delta_y,
  input  dir_flags_t                q_dir,
  input  logic [LR_COLOUR_BITS-1:0] q_colour,
  // pixel side
  output logic                      pix_valid,
  input  logic                      pix_ready,
  output logic [COORD_BITS-1:0]     pix_x,
  output logic [COORD_BITS-1:0]     pix_y,
  output logic [LR_COLOUR_BITS-1:0] pix_colour,
  output logic                      pix_last
);

  localparam int DW = COORD_BITS + 3;

  logic                      active_r, active_nxt;
  logic                      valid_r, valid_nxt;
  logic                      last_r, last_nxt;
  logic [COORD_BITS-1:0]     cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0]     cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0]     tgt_x_r, tgt_x_nxt;
  logic [COORD_BITS-1:0]     tgt_y_r, tgt_y_nxt;
  logic signed [DW-1:0]      dec_r, dec_nxt;
  logic signed [DW-1:0]      inc_diag_r, inc_diag_nxt;
  logic signed [DW-1:0]      inc_axis_r, inc_axis_nxt;
  logic                      y_major_r, y_major_nxt;
  dir_flags_t                dir_r, dir_nxt;
  logic [LR_COLOUR_BITS-1:0] colour_r, colour_nxt;

  logic                      s_y_major;
  logic [COORD_BITS-1:0]     s_major;
  logic [COORD_BITS-1:0]     s_minor;
  logic                      minor_step;
  logic [COORD_BITS-1:0]     x_moved;
  logic [COORD_BITS-1:0]     y_moved;

  // Take a request whenever the pixel register is free or being drained
  assign q_pop = q_valid && (!valid_r || pix_ready);

  // Current position is the pixel on show: it only moves on a pop
  assign pix_valid  = valid_r;
  assign pix_x      = cur_x_r;
  assign pix_y      = cur_y_r;
  assign pix_colour = colour_r;
  assign pix_last   = last_r;

  always_comb begin
    s_y_major  = q_delta_y >= q_delta_x;
    s_major    = s_y_major ? q_delta_y : q_delta_x;
    s_minor    = s_y_major ? q_delta_x : q_delta_y;
    minor_step = !dec_r[DW-1];
    x_moved    = dir_r.x_neg ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1);
    y_moved    = dir_r.y_neg ? cur_y_r - COORD_BITS'(1) : cur_y_r + COORD_BITS'(1);

    active_nxt   = active_r;
    last_nxt     = last_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    tgt_x_nxt    = tgt_x_r;
    tgt_y_nxt    = tgt_y_r;
    dec_nxt      = dec_r;
    inc_diag_nxt = inc_diag_r;
    inc_axis_nxt = inc_axis_r;
    y_major_nxt  = y_major_r;
    dir_nxt      = dir_r;
    colour_nxt   = colour_r;
    valid_nxt    = valid_r && !pix_ready;

    if (q_pop) begin
      case (q_cmd)
        CMD_START: begin
          y_major_nxt  = s_y_major;
          dir_nxt      = q_dir;
          dec_nxt      = DW'({s_minor, 1'b0}) - DW'(s_major);
          inc_axis_nxt = DW'({s_minor, 1'b0});
          inc_diag_nxt = DW'({s_minor, 1'b0}) - DW'({s_major, 1'b0});
          cur_x_nxt    = q_start_x;
          cur_y_nxt    = q_start_y;
          tgt_x_nxt    = q_end_x;
          tgt_y_nxt    = q_end_y;
          colour_nxt   = q_colour;
          last_nxt     = (q_delta_x == '0) && (q_delta_y == '0);
          active_nxt   = !last_nxt;
          valid_nxt    = 1'b1;
        end
        CMD_ADVANCE: begin
          // Drop an advance that arrives with no line running
          if (active_r) begin
            dec_nxt = dec_r + (minor_step ? inc_diag_r : inc_axis_r);
            if (y_major_r) begin
              cur_y_nxt = y_moved;
              if (minor_step) begin
                cur_x_nxt = x_moved;
              end
              last_nxt = y_moved == tgt_y_r;
            end else begin
              cur_x_nxt = x_moved;
              if (minor_step) begin
                cur_y_nxt = y_moved;
              end
              last_nxt = x_moved == tgt_x_r;
            end
            active_nxt = !last_nxt;
            valid_nxt  = 1'b1;
          end
        end
        default: begin
          valid_nxt = valid_r && !pix_ready;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    tgt_x_r    <= tgt_x_nxt;
    tgt_y_r    <= tgt_y_nxt;
    dec_r      <= dec_nxt;
    inc_diag_r <= inc_diag_nxt;
    inc_axis_r <= inc_axis_nxt;
    y_major_r  <= y_major_nxt;
    dir_r      <= dir_nxt;
    colour_r   <= colour_nxt;
  end

endmodule

// ===== hdl/line_rasterizer.sv =====
`timescale 1ns / 1ps
// Bresenham line rasterizer, all eight octants.
// Input channel (in_valid / in_ready): one request per handshake. A start
// request (command 0) loads both endpoints and the colour and yields the
// first pixel; an advance request (command 1) yields the next pixel along
// the major axis. An advance with no line running yields nothing.
// Output channel (out_valid / out_ready): one pixel per handshake, with its
// colour, an on-screen flag (write enable for frame memory) and a flag on
// the end point, which also ends the line.
// A request passes through the setup queue and then the stepping register
// before its pixel can be handed over.
// Throughput: one request and one pixel per clock while out_ready is high;
// each step is a single decision add plus a coordinate increment and
// compare in the stepper. A two-entry queue parts setup from stepping;
// if the receiver stalls, the queue fills and in_ready drops once it holds
// two requests, and the waiting pixel holds unchanged.
// Reset (rst_n low at a clock edge) empties the queue, drops any pending
// pixel and ends any running line.
module line_rasterizer
  import lr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = LR_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = LR_SCREEN_HEIGHT,
  parameter int COORD_BITS    = LR_COORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // request channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_command,
  input  logic [COORD_BITS-1:0]   in_start_x,
  input  logic [COORD_BITS-1:0]   in_start_y,
  input  logic [COORD_BITS-1:0]   in_end_x,
  input  logic [COORD_BITS-1:0]   in_end_y,
  input  logic [LR_CHAN_BITS-1:0] in_red_in,
  input  logic [LR_CHAN_BITS-1:0] in_green_in,
  input  logic [LR_CHAN_BITS-1:0] in_blue_in,
  // pixel channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COORD_BITS-1:0]   out_pixel_x,
  output logic [COORD_BITS-1:0]   out_pixel_y,
  output logic [LR_CHAN_BITS-1:0] out_red_out,
  output logic [LR_CHAN_BITS-1:0] out_green_out,
  output logic [LR_CHAN_BITS-1:0] out_blue_out,
  output logic                    out_on_screen,
  output logic                    out_last_pixel
);

  // Queue entry: command, endpoints, spans, directions, colour
  localparam int EW = 1 + 6 * COORD_BITS + LR_DIR_BITS + LR_COLOUR_BITS;
  // Screen limits compared at 17 bits, wider than the default coordinates
  localparam int LW = 17;
  localparam logic [LW-1:0] SCREEN_W_L = LW'(SCREEN_WIDTH);
  localparam logic [LW-1:0] SCREEN_H_L = LW'(SCREEN_HEIGHT);

  logic [COORD_BITS-1:0]     f_delta_x;
  logic [COORD_BITS-1:0]     f_delta_y;
  dir_flags_t                f_dir;
  logic [EW-1:0]             wr_entry;
  logic [EW-1:0]             rd_entry;
  logic                      q_valid;
  logic                      q_pop;
  logic                      q_cmd_bit;
  cmd_t                      q_cmd;
  logic [COORD_BITS-1:0]     q_start_x;
  logic [COORD_BITS-1:0]     q_start_y;
  logic [COORD_BITS-1:0]     q_end_x;
  logic [COORD_BITS-1:0]     q_end_y;
  logic [COORD_BITS-1:0]     q_delta_x;
  logic [COORD_BITS-1:0]     q_delta_y;
  dir_flags_t                q_dir;
  logic [LR_COLOUR_BITS-1:0] q_colour;
  logic [LR_COLOUR_BITS-1:0] pix_colour;

  // Front: spans and directions of each request, computed on the way in
  lr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .start_x(in_start_x),
    .start_y(in_start_y),
    .end_x  (in_end_x),
    .end_y  (in_end_y),
    .delta_x(f_delta_x),
    .delta_y(f_delta_y),
    .dir    (f_dir)
  );

  assign wr_entry = {in_command, in_start_x, in_start_y, in_end_x, in_end_y,
                     f_delta_x, f_delta_y, f_dir, in_red_in, in_green_in, in_blue_in};

  // Queue: decouples setup from stepping so each side stalls on its own
  lr_fifo #(
    .WIDTH(EW),
    .DEPTH(LR_QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(in_valid),
    .wr_ready(in_ready),
    .wr_data (wr_entry),
    .rd_valid(q_valid),
    .rd_pop  (q_pop),
    .rd_data (rd_entry)
  );

  assign {q_cmd_bit, q_start_x, q_start_y, q_end_x, q_end_y,
          q_delta_x, q_delta_y, q_dir, q_colour} = rd_entry;
  assign q_cmd = cmd_t'(q_cmd_bit);

  // Back: line state, decision term and the output pixel register
  lr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .q_start_x (q_start_x),
    .q_start_y (q_start_y),
    .q_end_x   (q_end_x),
    .q_end_y   (q_end_y),
    .q_delta_x (q_delta_x),
    .q_delta_y (q_delta_y),
    .q_dir     (q_dir),
    .q_colour  (q_colour),
    .pix_valid (out_valid),
    .pix_ready (out_ready),
    .pix_x     (out_pixel_x),
    .pix_y     (out_pixel_y),
    .pix_colour(pix_colour),
    .pix_last  (out_last_pixel)
  );

  assign {out_red_out, out_green_out, out_blue_out} = pix_colour;

  // Write enable: clear for pixels beyond the screen edges
  assign out_on_screen = (LW'(out_pixel_x) < SCREEN_W_L) && (LW'(out_pixel_y) < SCREEN_H_L);

endmodule

// ===== hdl/lr_checker.sv =====
`timescale 1ns / 1ps

module lr_checker
  import lr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = LR_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = LR_SCREEN_HEIGHT,
  parameter int COORD_BITS    = LR_COORD_BITS
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [COORD_BITS-1:0]   out_pixel_x,
  input logic [COORD_BITS-1:0]   out_pixel_y,
  input logic [LR_CHAN_BITS-1:0] out_red_out,
  input logic [LR_CHAN_BITS-1:0] out_green_out,
  input logic [LR_CHAN_BITS-1:0] out_blue_out,
  input logic                    out_on_screen,
  input logic                    out_last_pixel
);

  localparam int LW = 17;
  localparam logic [LW-1:0] SCREEN_W_L = LW'(SCREEN_WIDTH);
  localparam logic [LW-1:0] SCREEN_H_L = LW'(SCREEN_HEIGHT);

  // A stalled pixel holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_x) && $stable(out_pixel_y)
      && $stable(out_red_out) && $stable(out_green_out) && $stable(out_blue_out)
      && $stable(out_last_pixel))
    else $error("pixel changed while stalled");

  // Reset leaves no pixel pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("pixel pending after reset");

  // A receiver that kept up last cycle leaves room in the queue
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_ready) |-> in_ready)
    else $error("input stalled while output drains");

  // Write enable follows the screen bounds
  a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_on_screen ==
      ((LW'(out_pixel_x) < SCREEN_W_L) && (LW'(out_pixel_y) < SCREEN_H_L)))
    else $error("on-screen flag disagrees with coordinates");

endmodule

bind line_rasterizer lr_checker #(
  .SCREEN_WIDTH (SCREEN_WIDTH),
  .SCREEN_HEIGHT(SCREEN_HEIGHT),
  .COORD_BITS   (COORD_BITS)
) u_lr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pixel_x   (out_pixel_x),
  .out_pixel_y   (out_pixel_y),
  .out_red_out   (out_red_out),
  .out_green_out (out_green_out),
  .out_blue_out  (out_blue_out),
  .out_on_screen (out_on_screen),
  .out_last_pixel(out_last_pixel)
);
